// ----- rtl/core/d2q_pkg.sv -----
// Shared types, constants and helpers for the decimal text to Q12 converter.
package d2q_pkg;

  localparam int unsigned FRAC_BITS   = 12;
  localparam int unsigned INT_W       = 24;
  localparam int unsigned FACC_W      = 14;
  localparam int unsigned RN_W        = 13;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned NUM_W       = FACC_W + FRAC_BITS;
  localparam int unsigned REC_W       = 27;
  localparam int unsigned PROD_W      = NUM_W + REC_W;
  localparam int unsigned MAG_W       = INT_W + FRAC_BITS + 1;

  // quotient position in the reciprocal product, per power of ten
  localparam int unsigned SH_1     = 26;
  localparam int unsigned SH_10    = 30;
  localparam int unsigned SH_100   = 33;
  localparam int unsigned SH_1000  = 36;
  localparam int unsigned SH_10000 = 40;

  localparam logic [CNT_W-1:0]  SIG_DIGITS = CNT_W'(4);
  localparam logic [FACC_W-1:0] SIG_SCALE  = FACC_W'(10000);

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_DOT   = 8'd46;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_EMPTY    = 3'd1,
    ERR_BAD      = 3'd2,
    ERR_TOO_MANY = 3'd3,
    ERR_LONE     = 3'd4,
    ERR_RANGE    = 3'd5
  } err_e;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SIGN,
    PH_INT,
    PH_FRAC
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_START,
    ST_DIV,
    ST_SCALE,
    ST_FINAL,
    ST_EMIT
  } ctrl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_NEG,
    OP_INT_FIRST,
    OP_INT_DIGIT,
    OP_FRAC_DIGIT,
    OP_FRAC_TAIL,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_SCALE,
    OP_FINAL,
    OP_ERR,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    err_e   err;
  } dp_cmd_t;

  typedef struct packed {
    logic is_num;
    logic is_dot;
    logic is_minus;
    logic eoi;
    logic int_over;
    logic frac_full;
    logic frac_last;
    logic lone;
  } dp_status_t;

  function automatic logic [FACC_W-1:0] pow10(input logic [CNT_W-1:0] n);
    logic [FACC_W-1:0] r;
    unique case (n)
      CNT_W'(0): r = FACC_W'(1);
      CNT_W'(1): r = FACC_W'(10);
      CNT_W'(2): r = FACC_W'(100);
      CNT_W'(3): r = FACC_W'(1000);
      default:   r = SIG_SCALE;
    endcase
    return r;
  endfunction

  // ceil(2^SH / 10^n): exact quotient for any 26-bit numerator
  function automatic logic [REC_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [REC_W-1:0] r;
    unique case (n)
      CNT_W'(0): r = REC_W'(67108864);
      CNT_W'(1): r = REC_W'(107374183);
      CNT_W'(2): r = REC_W'(85899346);
      CNT_W'(3): r = REC_W'(68719477);
      default:   r = REC_W'(109951163);
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/d2q_dp.sv -----
// Datapath: accumulators, reciprocal divider, rounding and result registers.
module d2q_dp #(
  parameter int unsigned MAX_INT_DIGITS = 6
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  d2q_pkg::dp_cmd_t     cmd_i,
  input  logic [7:0]           ch_i,
  input  logic                 end_of_input_i,
  output d2q_pkg::dp_status_t  status_o,
  output logic signed [31:0]   value_o,
  output logic [2:0]           error_code_o
);
  import d2q_pkg::*;

  logic [7:0]        ch_q;
  logic              eoi_q;
  logic              neg_q, neg_d;
  logic [INT_W-1:0]  int_q, int_d;
  logic [CNT_W-1:0]  icnt_q, icnt_d;
  logic [FACC_W-1:0] facc_q, facc_d;
  logic [CNT_W-1:0]  fcnt_q, fcnt_d;
  logic [RN_W-1:0]   rn_q, rn_d;
  logic [RN_W-1:0]   thr_q, thr_d;
  logic              dec_q, dec_d;
  logic [NUM_W-1:0]  num_q;
  logic [REC_W-1:0]  rec_q;
  logic [CNT_W-1:0]  dsel_q;
  logic [RN_W-1:0]   quo_q, quo_d;
  logic [31:0]       pval_q;
  err_e              perr_q;
  logic [31:0]       val_q;
  err_e              err_q;

  logic [3:0]        dig;
  logic [FACC_W-1:0] den_new;
  logic [PROD_W-1:0] prod;
  logic [RN_W:0]     odd;
  logic [27:0]       scaled;
  logic [16:0]       t10;
  logic [3:0]        td;
  logic [RN_W-1:0]   frac;
  logic [MAG_W-1:0]  mag;
  logic              range_bad;

  assign dig     = ch_q[3:0];
  assign den_new = pow10(fcnt_q);

  assign prod = PROD_W'(num_q) * PROD_W'(rec_q);

  always_comb begin
    unique case (dsel_q)
      CNT_W'(0): quo_d = prod[SH_1 +: RN_W];
      CNT_W'(1): quo_d = prod[SH_10 +: RN_W];
      CNT_W'(2): quo_d = prod[SH_100 +: RN_W];
      CNT_W'(3): quo_d = prod[SH_1000 +: RN_W];
      default:   quo_d = prod[SH_10000 +: RN_W];
    endcase
  end

  assign odd    = {quo_q, 1'b1};
  assign scaled = 28'(odd) * 28'(SIG_SCALE);
  assign t10    = 17'(thr_q) * 17'(10);
  assign td     = t10[16:13];
  assign frac   = (fcnt_q == SIG_DIGITS) ? rn_q : quo_q;
  assign mag    = {1'b0, int_q, {FRAC_BITS{1'b0}}} + MAG_W'(frac);
  assign range_bad = neg_q ? (mag > MAG_W'(33'h0_8000_0000))
                           : (mag > MAG_W'(33'h0_7FFF_FFFF));

  always_comb begin
    neg_d  = neg_q;
    int_d  = int_q;
    icnt_d = icnt_q;
    facc_d = facc_q;
    fcnt_d = fcnt_q;
    rn_d   = rn_q;
    thr_d  = thr_q;
    dec_d  = dec_q;
    unique case (cmd_i.op)
      OP_NEG:       neg_d = 1'b1;
      OP_INT_FIRST: begin
        int_d  = INT_W'(dig);
        icnt_d = CNT_W'(1);
      end
      OP_INT_DIGIT: begin
        int_d  = INT_W'(int_q * INT_W'(10)) + INT_W'(dig);
        icnt_d = icnt_q + CNT_W'(1);
      end
      OP_FRAC_DIGIT: begin
        facc_d = FACC_W'(facc_q * FACC_W'(10)) + FACC_W'(dig);
        fcnt_d = fcnt_q + CNT_W'(1);
      end
      OP_FRAC_TAIL: begin
        if (!dec_q) begin
          if (dig != td) begin
            if (dig > td) rn_d = rn_q + RN_W'(1);
            dec_d = 1'b1;
          end else begin
            thr_d = t10[RN_W-1:0];
          end
        end
      end
      OP_SCALE: begin
        rn_d  = quo_q;
        thr_d = scaled[RN_W-1:0];
        dec_d = (scaled[27:13] != {1'b0, facc_q});
      end
      OP_EMIT: begin
        neg_d  = 1'b0;
        int_d  = '0;
        icnt_d = '0;
        facc_d = '0;
        fcnt_d = '0;
        rn_d   = '0;
        thr_d  = '0;
        dec_d  = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q  <= 1'b0;
      int_q  <= '0;
      icnt_q <= '0;
      facc_q <= '0;
      fcnt_q <= '0;
      rn_q   <= '0;
      thr_q  <= '0;
      dec_q  <= 1'b0;
    end else begin
      neg_q  <= neg_d;
      int_q  <= int_d;
      icnt_q <= icnt_d;
      facc_q <= facc_d;
      fcnt_q <= fcnt_d;
      rn_q   <= rn_d;
      thr_q  <= thr_d;
      dec_q  <= dec_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      ch_q  <= ch_i;
      eoi_q <= end_of_input_i;
    end
    if (cmd_i.op == OP_DIV_START) begin
      num_q  <= {facc_q, {FRAC_BITS{1'b0}}} + NUM_W'(den_new >> 1);
      rec_q  <= recip(fcnt_q);
      dsel_q <= fcnt_q;
    end
    if (cmd_i.op == OP_DIV_STEP) begin
      quo_q <= quo_d;
    end
    if (cmd_i.op == OP_ERR) begin
      pval_q <= '0;
      perr_q <= cmd_i.err;
    end else if (cmd_i.op == OP_FINAL) begin
      pval_q <= range_bad ? 32'd0 : (neg_q ? 32'd0 - mag[31:0] : mag[31:0]);
      perr_q <= range_bad ? ERR_RANGE : ERR_OK;
    end
    if (cmd_i.op == OP_EMIT) begin
      val_q <= pval_q;
      err_q <= perr_q;
    end
  end

  assign status_o.is_num    = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
  assign status_o.is_dot    = (ch_q == CH_DOT);
  assign status_o.is_minus  = (ch_q == CH_MINUS);
  assign status_o.eoi       = eoi_q;
  assign status_o.int_over  = (icnt_q > CNT_W'(MAX_INT_DIGITS));
  assign status_o.frac_full = (fcnt_q == SIG_DIGITS);
  assign status_o.frac_last = (fcnt_q == SIG_DIGITS - CNT_W'(1));
  assign status_o.lone      = (icnt_q == '0) && (fcnt_q == '0);

  assign value_o      = signed'(val_q);
  assign error_code_o = err_q;

endmodule

// ----- rtl/core/d2q_ctrl.sv -----
// Controller: parse phase, sequencing of the datapath, result handshake.
module d2q_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  d2q_pkg::dp_status_t status_i,
  output d2q_pkg::dp_cmd_t    cmd_o
);
  import d2q_pkg::*;

  ctrl_state_e state_q, state_d;
  phase_e      phase_q, phase_d;
  logic        fin_q, fin_d;
  logic        out_valid_q, out_valid_d;
  logic        emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    fin_d      = fin_q;
    cmd_o.op   = OP_NONE;
    cmd_o.err  = ERR_OK;
    in_ready_o = 1'b0;
    emit       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_IDLE;
        fin_d   = 1'b0;
        unique case (phase_q)
          PH_IDLE, PH_SIGN: begin
            priority if (status_i.eoi) begin
              cmd_o.op  = OP_ERR;
              cmd_o.err = ERR_EMPTY;
              state_d   = ST_EMIT;
            end else if (phase_q == PH_IDLE && status_i.is_minus) begin
              cmd_o.op = OP_NEG;
              phase_d  = PH_SIGN;
            end else if (status_i.is_num) begin
              cmd_o.op = OP_INT_FIRST;
              phase_d  = PH_INT;
            end else if (status_i.is_dot) begin
              phase_d = PH_FRAC;
            end else begin
              cmd_o.op  = OP_ERR;
              cmd_o.err = ERR_BAD;
              state_d   = ST_EMIT;
            end
          end
          PH_INT: begin
            priority if (!status_i.eoi && status_i.is_num) begin
              if (status_i.int_over) begin
                cmd_o.op  = OP_ERR;
                cmd_o.err = ERR_TOO_MANY;
                state_d   = ST_EMIT;
              end else begin
                cmd_o.op = OP_INT_DIGIT;
              end
            end else if (!status_i.eoi && status_i.is_dot) begin
              phase_d = PH_FRAC;
            end else begin
              fin_d   = 1'b1;
              state_d = status_i.frac_full ? ST_FINAL : ST_DIV_START;
            end
          end
          default: begin
            priority if (!status_i.eoi && status_i.is_num) begin
              if (status_i.frac_full) begin
                cmd_o.op = OP_FRAC_TAIL;
              end else begin
                cmd_o.op = OP_FRAC_DIGIT;
                if (status_i.frac_last) state_d = ST_DIV_START;
              end
            end else if (status_i.lone) begin
              cmd_o.op  = OP_ERR;
              cmd_o.err = ERR_LONE;
              state_d   = ST_EMIT;
            end else begin
              fin_d   = 1'b1;
              state_d = status_i.frac_full ? ST_FINAL : ST_DIV_START;
            end
          end
        endcase
      end
      ST_DIV_START: begin
        cmd_o.op = OP_DIV_START;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        state_d  = fin_q ? ST_FINAL : ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.op = OP_SCALE;
        state_d  = ST_IDLE;
      end
      ST_FINAL: begin
        cmd_o.op = OP_FINAL;
        state_d  = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = OP_EMIT;
          emit     = 1'b1;
          phase_d  = PH_IDLE;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = emit || (out_valid_q && !out_ready_i);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_emit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> (phase_q == PH_IDLE) && out_valid_q)
    else $error("emit did not restart parsing");
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == ST_DECODE)
    else $error("accepted transfer not decoded");
  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |=> (state_q == ST_FINAL || state_q == ST_SCALE))
    else $error("divide step did not end");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !emit)
    else $error("pending result overwritten");
`endif

endmodule

// ----- rtl/core/decimal_text_to_q12_fixed.sv -----
// Top level: decimal text to signed Q19.12 converter.
// Plain characters are accepted, then decoded; the fourth fraction digit adds setup,
// reciprocal multiply and rounding threshold steps. After the ending transfer a result
// passes decode and emit on an error, decode, final and emit with four or more fraction
// digits, else divide setup and step before final; a held result stalls the next one.
// Asynchronous active-low reset returns the parser to idle with no result pending.
module decimal_text_to_q12_fixed #(
  parameter int unsigned MAX_INT_DIGITS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         ch_i,
  input  logic               end_of_input_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] value_o,
  output logic [2:0]         error_code_o
);
  import d2q_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  d2q_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  d2q_dp #(
    .MAX_INT_DIGITS (MAX_INT_DIGITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .ch_i           (ch_i),
    .end_of_input_i (end_of_input_i),
    .status_o       (status),
    .value_o        (value_o),
    .error_code_o   (error_code_o)
  );

endmodule

// ----- dv/decimal_text_to_q12_fixed_tb.sv -----
// Testbench for the decimal text to Q12 converter: directed and random character streams checked against a predictor.
`timescale 1ns / 1ps
module decimal_text_to_q12_fixed_tb;
  import d2q_pkg::*;

  localparam int unsigned MAX_DIG = 6;
  localparam int unsigned LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } char_t;

  typedef struct packed {
    logic [31:0] value;
    err_e        err;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] ch_i = '0;
  logic end_of_input_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] value_o;
  logic [2:0] error_code_o;

  decimal_text_to_q12_fixed #(.MAX_INT_DIGITS(MAX_DIG)) uut (.*);

  always #10 clk_i = ~clk_i;

  char_t   pending_chars[$];
  result_t expected_results[$];
  int mismatches = 0;
  int cycle_count = 0;
  bit quiet_stretch = 1'b0;
  bit stim_done = 1'b0;

  // parser state copy
  phase_e     p_phase;
  logic       p_neg;
  logic [23:0] p_int;
  logic [2:0]  p_icnt;
  logic [13:0] p_frac;
  logic [2:0]  p_fcnt;
  logic [12:0] p_rnum;
  logic [12:0] p_thr;
  logic        p_dec;

  function automatic bit is_num_char(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  task automatic clear_parser();
    p_phase = PH_IDLE; p_neg = 0; p_int = 0; p_icnt = 0; p_frac = 0;
    p_fcnt = 0; p_rnum = 0; p_thr = 0; p_dec = 0;
  endtask

  task automatic push_result(logic [31:0] v, err_e e);
    result_t r;
    r.value = v;
    r.err = e;
    expected_results.insert(expected_results.size(), r);
    clear_parser();
  endtask

  task automatic add_fraction_digit(int unsigned d);
    int unsigned r, sc, t10, td;
    if (p_fcnt < 4) begin
      p_frac = 14'(p_frac * 10 + d);
      p_fcnt = 3'(p_fcnt + 1);
      if (p_fcnt == 4) begin
        r = ((int'(p_frac) << 12) + 5000) / 10000;
        sc = (2 * r + 1) * 10000;
        p_rnum = 13'(r);
        p_thr = 13'(sc & 8191);
        p_dec = (sc >> 13) != p_frac;
      end
    end else if (!p_dec) begin
      t10 = p_thr * 10;
      td = t10 >> 13;
      if (d != td) begin
        if (d > td) p_rnum = 13'(p_rnum + 1);
        p_dec = 1;
      end else begin
        p_thr = 13'(t10 & 8191);
      end
    end
  endtask

  task automatic finish_number();
    longint unsigned fr, mag, den;
    if (p_phase == PH_FRAC && p_icnt == 0 && p_fcnt == 0) begin
      push_result('0, ERR_LONE);
      return;
    end
    if (p_fcnt >= 4) fr = p_rnum;
    else begin
      den = (p_fcnt == 0) ? 1 : (p_fcnt == 1) ? 10 : (p_fcnt == 2) ? 100 : 1000;
      fr = ((longint'(p_frac) << 12) + den / 2) / den;
    end
    mag = (longint'(p_int) << 12) + fr;
    if (p_neg) begin
      if (p_int > 524288 || mag > 64'h8000_0000) push_result('0, ERR_RANGE);
      else push_result(32'(-mag), ERR_OK);
    end else begin
      if (p_int >= 524288 || mag > 64'h7FFF_FFFF) push_result('0, ERR_RANGE);
      else push_result(32'(mag), ERR_OK);
    end
  endtask

  task automatic predict_char(char_t it);
    unique case (p_phase)
      PH_IDLE, PH_SIGN: begin
        if (it.eoi) push_result('0, ERR_EMPTY);
        else if (p_phase == PH_IDLE && it.ch == CH_MINUS) begin
          p_neg = 1; p_phase = PH_SIGN;
        end else if (is_num_char(it.ch)) begin
          p_int = 24'(it.ch - CH_ZERO); p_icnt = 1; p_phase = PH_INT;
        end else if (it.ch == CH_DOT) p_phase = PH_FRAC;
        else push_result('0, ERR_BAD);
      end
      PH_INT: begin
        if (it.eoi) finish_number();
        else if (is_num_char(it.ch)) begin
          if (p_icnt > MAX_DIG) push_result('0, ERR_TOO_MANY);
          else begin
            p_int = 24'(p_int * 10 + (it.ch - CH_ZERO));
            p_icnt = 3'(p_icnt + 1);
          end
        end else if (it.ch == CH_DOT) p_phase = PH_FRAC;
        else finish_number();
      end
      default: begin
        if (!it.eoi && is_num_char(it.ch)) add_fraction_digit(32'(it.ch - CH_ZERO));
        else finish_number();
      end
    endcase
  endtask

  task automatic queue_char(logic [7:0] c, logic e);
    char_t it;
    it.ch = c;
    it.eoi = e;
    pending_chars.insert(pending_chars.size(), it);
  endtask

  task automatic queue_text(string s, bit with_eoi);
    foreach (s[i]) queue_char(s[i], 1'b0);
    if (with_eoi) queue_char(8'($urandom), 1'b1);
  endtask

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_end_char();
    logic [7:0] c;
    do c = 8'($urandom); while (is_num_char(c) || c == CH_DOT);
    return c;
  endfunction

  task automatic queue_random_number();
    int ni, nf, k;
    k = $urandom_range(0, 99);
    if (k < 10) begin
      repeat ($urandom_range(1, 4)) queue_char(8'($urandom), $urandom_range(0, 3) == 0);
      return;
    end
    if ($urandom_range(0, 2) == 0) queue_char(CH_MINUS, 1'b0);
    ni = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : $urandom_range(0, 7);
    if (k < 20) ni = 7;
    for (int i = 0; i < ni; i++)
      queue_char((k < 20 && i == 0) ? 8'd53 : rand_digit(), 1'b0);
    if ($urandom_range(0, 3) != 0) begin
      queue_char(CH_DOT, 1'b0);
      nf = $urandom_range(0, 12);
      for (int i = 0; i < nf; i++) queue_char(rand_digit(), 1'b0);
    end
    if ($urandom_range(0, 1)) queue_char(8'($urandom), 1'b1);
    else queue_char(rand_end_char(), 1'b0);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      predict_char({ch_i, end_of_input_i});
    end
    if (!in_valid_i || in_ready_o) begin
      if (pending_chars.size() != 0 && (quiet_stretch || $urandom_range(0, 99) >= 33)) begin
        char_t it;
        it = pending_chars.pop_front();
        in_valid_i <= 1'b1;
        ch_i <= it.ch;
        end_of_input_i <= it.eoi;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= quiet_stretch || $urandom_range(0, 99) >= 33;
  end

  // monitor
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected transfer: value %h code %0d",
                                      value_o, error_code_o);
      end else begin
        result_t r;
        r = expected_results.pop_front();
        if (r.value !== value_o || r.err !== error_code_o) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected value %h code %0d, got value %h code %0d",
                     r.value, r.err, value_o, error_code_o);
        end
      end
    end
    if (cycle_count > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    clear_parser();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_text("0", 1);
    queue_text("-", 1);
    queue_char(8'd0, 1'b1);
    queue_text("x", 0);
    queue_text("-a", 0);
    queue_text("12345678", 0);
    queue_text("9", 1);
    queue_text(".", 1);
    queue_text("-.", 0);
    queue_text(" ", 0);
    queue_text("524287.99999", 1);
    queue_text("524288 ", 0);
    queue_text("-524288", 1);
    queue_text("-524288.0001", 1);
    queue_text("0.99999 ", 0);
    queue_text("1.00012207031250", 1);
    queue_text("-0.5,", 0);
    queue_text(".25", 1);
    queue_text("9999999.", 1);
    queue_char(8'hFF, 1'b0);
    queue_char(8'h00, 1'b1);
    for (int n = 0; n < 190; n++) begin
      queue_random_number();
    end
    while (pending_chars.size() != 0) begin
      @(posedge clk_i);
      quiet_stretch = (cycle_count > 2000 && cycle_count < 3500);
    end
    quiet_stretch = 1'b0;
    while (in_valid_i || expected_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
